@@ rtl/core/mecp_pkg.sv @@
// ----------------------------------------------------------------------------
// mecp_pkg
// Shared types and constants for the mesh edge constraint pairing block.
// ----------------------------------------------------------------------------
package mecp_pkg;

  localparam int unsigned VTX_W            = 9;
  localparam int unsigned MAX_VERTICES_DEF = 512;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam int unsigned ENTRY_W = VTX_W + 1;
  localparam int unsigned SEEN_B  = VTX_W;

  localparam logic KIND_STRUCT = 1'b0;
  localparam logic KIND_BEND   = 1'b1;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_CA = 2'd2
  } edge_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

endpackage

@@ rtl/core/mesh_edge_constraint_pairing_top.sv @@
// ----------------------------------------------------------------------------
// mesh_edge_constraint_pairing_top
// Walks the edges AB, BC and CA of each triangle through a single-port
// edge table and emits one structural or bending pair per edge.
//
//   channel | dir | fields
//   in_     | in  | tdata: vertex_first, vertex_second, vertex_third
//   out_    | out | tdata: end_one, end_two; tuser: constraint_kind;
//           |     | tlast: last_of_triangle
//
// Each edge goes through a table read state and a decide/write state on
// the single table port, S_READ then S_DECIDE, for edges AB, BC and CA in
// turn after the triangle is accepted; a stalled output holds the sequencer.
// After reset a clearing pass writes zero to all MAX_VERTICES*MAX_VERTICES
// table entries; no triangle is taken meanwhile.
// ----------------------------------------------------------------------------
module mesh_edge_constraint_pairing_top
  import mecp_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // vertex_first, vertex_second, vertex_third
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // end_one, end_two
  output logic [OUT_TUSER_W-1:0] out_tuser,  // constraint_kind
  output logic                   out_tlast
);

  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW    = (MW > VTX_W) ? MW : VTX_W;

  state_t                 state_r, state_nxt;
  edge_sel_t              edge_r, edge_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [VTX_W-1:0]       va_r, vb_r, vc_r;
  logic [AW-1:0]          addr_r;
  logic                   inr_r;
  logic [ENTRY_W-1:0]     rdata_r;
  logic [ENTRY_W-1:0]     mem [DEPTH];

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_last_r;
  logic [VTX_W-1:0]       out_one_r, out_two_r;

  logic [VTX_W-1:0]       ea, eb, eo, lo, hi;
  logic                   inr;
  logic [AW-1:0]          edge_addr;
  logic                   out_free, load, seen, kind;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_addr;
  logic [ENTRY_W-1:0]     mem_wdata;

  always_comb begin
    case (edge_r)
      EDGE_AB: begin
        ea = va_r; eb = vb_r; eo = vc_r;
      end
      EDGE_BC: begin
        ea = vb_r; eb = vc_r; eo = va_r;
      end
      EDGE_CA: begin
        ea = vc_r; eb = va_r; eo = vb_r;
      end
      default: begin
        ea = vc_r; eb = va_r; eo = vb_r;
      end
    endcase
  end

  assign lo        = (ea < eb) ? ea : eb;
  assign hi        = (ea < eb) ? eb : ea;
  assign inr       = (CW'(hi) < CW'(MAX_VERTICES));
  assign edge_addr = AW'(lo) * AW'(MAX_VERTICES) + AW'(hi);

  assign out_free  = !out_valid_r || out_tready;
  assign load      = (state_r == S_DECIDE) && out_free;
  assign seen      = rdata_r[SEEN_B];
  assign kind      = inr_r && seen;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = {1'b1, eo};
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
      end
      S_READ: begin
        mem_re   = inr;
        mem_addr = edge_addr;
      end
      S_DECIDE: begin
        mem_we = load && inr_r && !seen;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    edge_nxt      = edge_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_READ;
          edge_nxt  = EDGE_AB;
        end
      end
      S_READ: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (edge_r == EDGE_CA) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
            edge_nxt  = (edge_r == EDGE_AB) ? EDGE_BC : EDGE_CA;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      edge_r      <= EDGE_AB;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_r      <= edge_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      va_r <= in_tdata[VTX_W-1:0];
      vb_r <= in_tdata[2*VTX_W-1:VTX_W];
      vc_r <= in_tdata[3*VTX_W-1:2*VTX_W];
    end
    if (state_r == S_READ) begin
      addr_r <= edge_addr;
      inr_r  <= inr;
    end
    if (load) begin
      out_kind_r <= kind ? KIND_BEND : KIND_STRUCT;
      out_one_r  <= kind ? eo : ea;
      out_two_r  <= kind ? rdata_r[VTX_W-1:0] : eb;
      out_last_r <= (edge_r == EDGE_CA);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2*VTX_W)'(0), out_two_r, out_one_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_stall_holds_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && !out_free) |=> ($stable(edge_r) && state_r == S_DECIDE))
    else $error("edge sequencer advanced under output stall");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (load && edge_r == EDGE_CA) |=> (in_tready && out_tlast && out_tvalid))
    else $error("third edge did not close the triangle");

  a_write_only_new: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (inr_r && !seen && load))
    else $error("table written for a seen or unrecorded edge");

  a_no_table_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!in_tready && !mem_re))
    else $error("activity during clearing pass");
`endif

endmodule

@@ tb/sv/tb_mesh_edge_constraint_pairing_top.sv @@
// ----------------------------------------------------------------------------
// tb_mesh_edge_constraint_pairing_top
// Self-checking bench for the mesh edge constraint pairing block. A short
// table of triangles covers the extremes, degenerate and shared edges, and
// edges seen three or more times. A random part follows, built mostly from
// triangles that reuse recent edges. Every output word is compared with a
// running model of the edge table or, for typed rows, a fixed word list.
// Both sides idle at random, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_mesh_edge_constraint_pairing_top;
  import mecp_pkg::*;

  localparam int N_DIRECTED     = 16;
  localparam int N_RANDOM       = 370;
  localparam int WATCHDOG_LIMIT = 800000;
  localparam int TAIL_CYCLES    = 30;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic             kind;
    logic [VTX_W-1:0] end_one;
    logic [VTX_W-1:0] end_two;
    logic             last;
  } pair_word_t;

  typedef struct packed {
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic [VTX_W-1:0] vc;
    logic             typed;
  } tri_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  bit         burst = 1'b0;
  int         err_count = 0;
  int         idle_cycles = 0;
  int         rdy_wait = 0;
  pair_word_t pending_pairs [$];
  logic [VTX_W-1:0] edge_opp [logic [2*VTX_W-1:0]];

  tri_row_t directed_rows [N_DIRECTED] = '{
    '{9'd1,   9'd2,   9'd3,   1'b1},
    '{9'd0,   9'd0,   9'd0,   1'b1},
    '{9'd511, 9'd511, 9'd511, 1'b1},
    '{9'd3,   9'd2,   9'd4,   1'b0},
    '{9'd2,   9'd1,   9'd5,   1'b0},
    '{9'd1,   9'd2,   9'd6,   1'b0},
    '{9'd2,   9'd1,   9'd7,   1'b0},
    '{9'd511, 9'd0,   9'd256, 1'b1},
    '{9'd0,   9'd511, 9'd255, 1'b0},
    '{9'd341, 9'd170, 9'd511, 1'b1},
    '{9'd170, 9'd341, 9'd0,   1'b0},
    '{9'd5,   9'd5,   9'd9,   1'b0},
    '{9'd9,   9'd5,   9'd5,   1'b0},
    '{9'd4,   9'd3,   9'd2,   1'b0},
    '{9'd3,   9'd4,   9'd2,   1'b0},
    '{9'd256, 9'd511, 9'd0,   1'b0}
  };

  pair_word_t typed_words [$] = '{
    {KIND_STRUCT, 9'd1,   9'd2,   1'b0},
    {KIND_STRUCT, 9'd2,   9'd3,   1'b0},
    {KIND_STRUCT, 9'd3,   9'd1,   1'b1},
    {KIND_STRUCT, 9'd0,   9'd0,   1'b0},
    {KIND_BEND,   9'd0,   9'd0,   1'b0},
    {KIND_BEND,   9'd0,   9'd0,   1'b1},
    {KIND_STRUCT, 9'd511, 9'd511, 1'b0},
    {KIND_BEND,   9'd511, 9'd511, 1'b0},
    {KIND_BEND,   9'd511, 9'd511, 1'b1},
    {KIND_STRUCT, 9'd511, 9'd0,   1'b0},
    {KIND_STRUCT, 9'd0,   9'd256, 1'b0},
    {KIND_STRUCT, 9'd256, 9'd511, 1'b1},
    {KIND_STRUCT, 9'd341, 9'd170, 1'b0},
    {KIND_STRUCT, 9'd170, 9'd511, 1'b0},
    {KIND_STRUCT, 9'd511, 9'd341, 1'b1}
  };

  mesh_edge_constraint_pairing_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic pair_word_t pair_edge(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                           logic [VTX_W-1:0] opp, logic last);
    logic [VTX_W-1:0]   lo;
    logic [VTX_W-1:0]   hi;
    logic [2*VTX_W-1:0] key;
    pair_word_t         w;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    key = {lo, hi};
    w = {KIND_STRUCT, a, b, last};
    if (int'(hi) < int'(MAX_VERTICES_DEF)) begin
      if (edge_opp.exists(key)) begin
        w = {KIND_BEND, opp, edge_opp[key], last};
      end else begin
        edge_opp[key] = opp;
      end
    end
    return w;
  endfunction

  task automatic send_triangle(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                               input logic [VTX_W-1:0] c, input logic typed);
    int         gap;
    pair_word_t w [3];
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    w[0] = pair_edge(a, b, c, 1'b0);
    w[1] = pair_edge(b, c, a, 1'b0);
    w[2] = pair_edge(c, a, b, 1'b1);
    for (int k = 0; k < 3; k++) begin
      if (typed) begin
        pending_pairs.push_back(typed_words.pop_front());
      end else begin
        pending_pairs.push_back(w[k]);
      end
    end
  endtask

  task automatic drain_pairs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pairs.size() != 0);
  endtask

  always @(posedge clk) begin
    int wait_draw;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_wait   <= 0;
    end else if (out_tready && out_tvalid) begin
      wait_draw = burst ? 0 : $urandom_range(0, 11);
      rdy_wait   <= wait_draw;
      out_tready <= (wait_draw == 0);
    end else if (!out_tready) begin
      if (rdy_wait <= 1) begin
        out_tready <= 1'b1;
      end else begin
        rdy_wait <= rdy_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    pair_word_t got;
    pair_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[VTX_W-1:0], out_tdata[2*VTX_W-1:VTX_W], out_tlast};
      if (pending_pairs.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected word: kind=%0d end_one=%0d end_two=%0d last=%0d",
                   got.kind, got.end_one, got.end_two, got.last);
        end
      end else begin
        want = pending_pairs.pop_front();
        if (got != want) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch: exp kind=%0d end_one=%0d end_two=%0d last=%0d",
                     want.kind, want.end_one, want.end_two, want.last);
            $display("          got kind=%0d end_one=%0d end_two=%0d last=%0d",
                     got.kind, got.end_one, got.end_two, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2*VTX_W-1:0] edge_pool [$];
    logic [2*VTX_W-1:0] e;
    logic [VTX_W-1:0]   a, b, c, p, q, r;
    int                 pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    edge_opp.delete();

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_triangle(directed_rows[i].va, directed_rows[i].vb, directed_rows[i].vc,
                    directed_rows[i].typed);
    end
    drain_pairs();

    for (int n = 0; n < N_RANDOM; n++) begin
      burst = (n >= 120 && n < 180);
      if (n == 250) drain_pairs();
      pick = $urandom_range(0, 99);
      if (pick < 60 && edge_pool.size() > 0) begin
        e = edge_pool[$urandom_range(0, edge_pool.size() - 1)];
        if ($urandom_range(0, 3) != 0) begin
          p = e[2*VTX_W-1:VTX_W];
          q = e[VTX_W-1:0];
        end else begin
          p = e[VTX_W-1:0];
          q = e[2*VTX_W-1:VTX_W];
        end
        if ($urandom_range(0, 1) == 1) begin
          r = 9'($urandom_range(0, 15));
        end else begin
          r = edge_pool[$urandom_range(0, edge_pool.size() - 1)][VTX_W-1:0];
        end
        case ($urandom_range(0, 2))
          0: begin
            a = p; b = q; c = r;
          end
          1: begin
            a = r; b = p; c = q;
          end
          default: begin
            a = q; b = r; c = p;
          end
        endcase
      end else if (pick < 85) begin
        a = 9'($urandom_range(0, 15));
        b = 9'($urandom_range(0, 15));
        c = 9'($urandom_range(0, 15));
      end else begin
        a = 9'($urandom);
        b = 9'($urandom);
        c = 9'($urandom);
      end
      send_triangle(a, b, c, 1'b0);
      edge_pool.push_back({b, a});
      edge_pool.push_back({c, b});
      edge_pool.push_back({a, c});
      while (edge_pool.size() > 48) void'(edge_pool.pop_front());
    end
    burst = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_pairs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ mesh_edge_constraint_pairing_top.f @@
rtl/core/mecp_pkg.sv
rtl/core/mesh_edge_constraint_pairing_top.sv
tb/sv/tb_mesh_edge_constraint_pairing_top.sv
